>>> src/assert_macros.svh
// Assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

>>> src/fgs_pkg.sv
// Package: constants, types and helpers for the gradient stencil
package fgs_pkg;
    localparam int MAX_ROWS = 1024;
    localparam int MAX_COLS = 1024;
    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);

    typedef enum logic [1:0] {
        REG_COLS = 2'd0,
        REG_ROWS = 2'd1,
        REG_IDX  = 2'd2,
        REG_IDY  = 2'd3
    } reg_idx_t;

    // point kinds that the front hands to the back
    typedef enum logic [1:0] {
        K_LOW  = 2'd0,
        K_MID  = 2'd1,
        K_HIGH = 2'd2
    } kind_t;

    // one point job: x stencil kind, position, last flag
    typedef struct packed {
        kind_t            kind;
        logic [CW-1:0]    px;
        logic [AW-1:0]    py;
        logic             last;
    } job_t;

    typedef struct packed {
        logic [CW-1:0]    px;
        logic [AW-1:0]    py;
        logic [31:0]      ex;
        logic [31:0]      ey;
        logic             last;
    } res_t;

    // -d * scale with round half away from zero and saturation
    function automatic logic [31:0] scale_neg(input logic signed [35:0] d,
                                             input logic [31:0] scale);
        logic        neg;
        logic [35:0] mag;
        logic [67:0] p;
        logic [52:0] q;
        begin
            neg = d[35];
            mag = neg ? 36'(-d) : 36'(d);
            p = 68'(mag) * 68'(scale);
            q = 53'((p + 68'h8000) >> 16);
            if (!neg)
                scale_neg = (q >= 53'h80000000) ? 32'h80000000 : 32'(-q);
            else
                scale_neg = (q > 53'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
        end
    endfunction
endpackage

>>> src/fgs_front.sv
// Front: line buffers, counters, and job scheduling for each sample
module fgs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [31:0]         phi,
    input  logic [10:0]         cols_cfg,
    input  logic [10:0]         rows_cfg,
    input  logic                restart,
    output logic                jvalid,
    output fgs_pkg::job_t       job,
    input  logic                jready,
    output logic [31:0]         s0,
    output logic [31:0]         s1,
    output logic [31:0]         s2,
    output logic [31:0]         t0,
    output logic [31:0]         t1,
    output logic [31:0]         t2
);
    import fgs_pkg::*;

    logic [31:0] line_a [MAX_ROWS];
    logic [31:0] line_b [MAX_ROWS];
    logic [31:0] line_c [MAX_ROWS];
    logic [1:0]  bank_reg;

    logic [CW-1:0] x_reg;
    logic [AW-1:0] y_reg;
    logic [CW:0]   cols;
    logic [AW:0]   rows;

    // job list of the current sample, emitted one per cycle while the back takes jobs and no second read is due
    typedef enum logic [1:0] { S_IDLE, S_RUN } st_t;
    st_t           st_reg;
    logic [2:0]    n_reg, i_reg;
    job_t          jl_reg [8];
    logic [2:0]    n_next;
    job_t          jl_next [8];
    logic          ph_reg;

    always_comb
    begin
        cols = (cols_cfg < 11'd3) ? 11'd3 : (cols_cfg > 11'(MAX_COLS)) ? 11'(MAX_COLS) : cols_cfg;
        rows = (rows_cfg < 11'd3) ? 11'd3 : (rows_cfg > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : rows_cfg;
    end

    assign full = (st_reg != S_IDLE);
    logic acc;
    assign acc = push && !full;

    always_comb
    begin
        n_next = 3'd0;
        for (int k = 0; k < 8; k++)
        begin
            jl_next[k] = '{kind: K_MID, px: '0, py: '0, last: 1'b0};
        end
        if (x_reg >= CW'(2))
        begin
            if (x_reg == CW'(2))
            begin
                jl_next[n_next] = '{kind: K_LOW, px: '0, py: y_reg, last: 1'b0};
                n_next = n_next + 3'd1;
            end
            jl_next[n_next] = '{kind: K_MID, px: x_reg - CW'(1), py: y_reg, last: 1'b0};
            n_next = n_next + 3'd1;
            if ({1'b0, x_reg} == cols - 11'd1 && y_reg >= AW'(2))
            begin
                if (y_reg == AW'(2))
                begin
                    jl_next[n_next] = '{kind: K_HIGH, px: CW'(cols - 11'd1), py: '0, last: 1'b0};
                    n_next = n_next + 3'd1;
                end
                jl_next[n_next] = '{kind: K_HIGH, px: CW'(cols - 11'd1), py: y_reg - AW'(1),
                                    last: 1'b0};
                n_next = n_next + 3'd1;
                if ({1'b0, y_reg} == rows - 11'd1)
                begin
                    jl_next[n_next] = '{kind: K_HIGH, px: CW'(cols - 11'd1),
                                        py: AW'(rows - 11'd1), last: 1'b0};
                    n_next = n_next + 3'd1;
                end
            end
        end
        // a fifth point (3x3 frame end) forms a burst of its own, so the fourth closes one
        for (int k = 0; k < 8; k++)
        begin
            jl_next[k].last = (k == int'(n_next) - 1) || (k == 3);
        end
    end

    // line roles rotate by bank: older, prior, current
    logic [1:0] bo, bp, bc;
    always_comb
    begin
        bc = bank_reg;
        bp = (bank_reg == 2'd0) ? 2'd2 : bank_reg - 2'd1;
        bo = (bp == 2'd0) ? 2'd2 : bp - 2'd1;
    end

    logic write_now;
    assign write_now = acc;

    always_ff @(posedge clk)
    begin
        if (write_now && bc == 2'd0) line_a[y_reg] <= phi;
        if (write_now && bc == 2'd1) line_b[y_reg] <= phi;
        if (write_now && bc == 2'd2) line_c[y_reg] <= phi;
    end

    // read address of the job about to be sent and its y neighbors
    job_t          cur;
    logic [AW-1:0] ya, yb, yc;
    logic [1:0]    ly;
    logic          need2;
    assign cur = jl_reg[i_reg];
    always_comb
    begin
        if (cur.py == '0)
        begin
            ya = AW'(0); yb = AW'(1); yc = AW'(2);
        end
        else if ({1'b0, cur.py} == rows - 11'd1)
        begin
            ya = AW'(rows - 11'd3); yb = AW'(rows - 11'd2); yc = AW'(rows - 11'd1);
        end
        else
        begin
            ya = cur.py - AW'(1); yb = cur.py; yc = cur.py + AW'(1);
        end
        case (cur.kind)
            K_LOW:   ly = bo;
            K_MID:   ly = bp;
            K_HIGH:  ly = bc;
            default: ly = bp;
        endcase
        // only interior middle points need no second read
        need2 = (cur.kind != K_MID) || (cur.py == '0) || ({1'b0, cur.py} == rows - 11'd1);
    end

    // job goes out in the cycle after its last read, with the read data
    logic jv_reg;
    job_t jq_reg;
    logic go, issue;
    assign jvalid = jv_reg;
    assign job = jq_reg;
    assign go = (st_reg == S_RUN) && (!jv_reg || jready);
    assign issue = go && (!need2 || ph_reg);

    logic [AW-1:0] a0 [3], a1 [3];
    logic [31:0]   p0_reg [3], p1_reg [3];
    logic [31:0]   ha_reg, hc_reg;
    logic [1:0]    bo_q, bp_q, bc_q, ly_q;
    logic          n2_q;

    // two reads per line buffer a cycle; the y end taps of a three-read point come first
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            a0[k] = cur.py;
            a1[k] = yb;
            if (2'(k) == ly && !(need2 && ph_reg))
            begin
                a0[k] = ya;
                a1[k] = yc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            p0_reg[0] <= line_a[a0[0]]; p1_reg[0] <= line_a[a1[0]];
            p0_reg[1] <= line_b[a0[1]]; p1_reg[1] <= line_b[a1[1]];
            p0_reg[2] <= line_c[a0[2]]; p1_reg[2] <= line_c[a1[2]];
        end
        if (issue)
        begin
            ha_reg <= p0_reg[ly];
            hc_reg <= p1_reg[ly];
            bo_q <= bo; bp_q <= bp; bc_q <= bc; ly_q <= ly;
            n2_q <= need2;
        end
    end

    // map banks to x stencil taps; y taps come from the selected line
    always_comb
    begin
        s0 = p0_reg[bo_q];
        s1 = p0_reg[bp_q];
        s2 = p0_reg[bc_q];
        if (n2_q)
        begin
            t0 = ha_reg; t1 = p1_reg[ly_q]; t2 = hc_reg;
        end
        else
        begin
            t0 = p0_reg[ly_q]; t1 = p1_reg[ly_q]; t2 = p1_reg[ly_q];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE;
            x_reg <= '0;
            y_reg <= '0;
            bank_reg <= 2'd0;
            n_reg <= '0;
            i_reg <= '0;
            jv_reg <= 1'b0;
            ph_reg <= 1'b0;
        end
        else
        begin
            if (jv_reg && jready) jv_reg <= 1'b0;
            if (go && need2 && !ph_reg) ph_reg <= 1'b1;
            if (issue)
            begin
                ph_reg <= 1'b0;
                jv_reg <= 1'b1;
                jq_reg <= cur;
                if (i_reg + 3'd1 == n_reg)
                begin
                    st_reg <= S_IDLE;
                    // the bank rotation waits until the last job has read the lines
                    if (y_reg == '0)
                    begin
                        bank_reg <= (bank_reg == 2'd2) ? 2'd0 : bank_reg + 2'd1;
                    end
                end
                i_reg <= i_reg + 3'd1;
            end
            if (restart)
            begin
                x_reg <= '0;
                y_reg <= '0;
            end
            else if (acc)
            begin
                n_reg <= n_next;
                i_reg <= '0;
                for (int k = 0; k < 8; k++) jl_reg[k] <= jl_next[k];
                if (n_next != 3'd0)
                    st_reg <= S_RUN;
                else if ({1'b0, y_reg} == rows - 11'd1)
                    bank_reg <= (bank_reg == 2'd2) ? 2'd0 : bank_reg + 2'd1;
                if ({1'b0, y_reg} + 11'd1 >= rows)
                begin
                    y_reg <= '0;
                    x_reg <= ({1'b0, x_reg} + 11'd1 >= cols) ? '0 : x_reg + CW'(1);
                end
                else
                    y_reg <= y_reg + AW'(1);
            end
        end
    end
endmodule

>>> src/fgs_back.sv
// Back: difference, scale, round and saturate, then result queue
module fgs_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                jvalid,
    input  fgs_pkg::job_t       job,
    output logic                jready,
    input  logic [31:0]         s0,
    input  logic [31:0]         s1,
    input  logic [31:0]         s2,
    input  logic [31:0]         t0,
    input  logic [31:0]         t1,
    input  logic [31:0]         t2,
    input  logic [10:0]         rows_cfg,
    input  logic [31:0]         idx,
    input  logic [31:0]         idy,
    output logic                empty,
    input  logic                pop,
    output fgs_pkg::res_t       res
);
    import fgs_pkg::*;

    localparam int QD = 8;
    logic signed [35:0] dx, dy;
    logic [AW:0] rows;
    assign rows = (rows_cfg < 11'd3) ? 11'd3 : (rows_cfg > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : rows_cfg;

    always_comb
    begin
        case (job.kind)
            K_LOW:   dx = -36'sd3 * 36'(signed'(s0)) + 36'sd4 * 36'(signed'(s1))
                          - 36'(signed'(s2));
            K_HIGH:  dx = 36'(signed'(s0)) - 36'sd4 * 36'(signed'(s1))
                          + 36'sd3 * 36'(signed'(s2));
            default: dx = 36'(signed'(s2)) - 36'(signed'(s0));
        endcase
        if (job.py == '0)
            dy = -36'sd3 * 36'(signed'(t0)) + 36'sd4 * 36'(signed'(t1)) - 36'(signed'(t2));
        else if ({1'b0, job.py} == rows - 11'd1)
            dy = 36'(signed'(t0)) - 36'sd4 * 36'(signed'(t1)) + 36'sd3 * 36'(signed'(t2));
        else
            dy = 36'(signed'(t2)) - 36'(signed'(t0));
    end

    res_t q_mem [QD];
    logic [2:0] wp_reg, rp_reg;
    logic [3:0] cnt_reg;

    // differences are registered before the scale multiply
    logic               sv_reg;
    logic signed [35:0] dx_reg, dy_reg;
    job_t               sj_reg;

    logic wr, rd, ld;
    assign wr = sv_reg && (cnt_reg < 4'(QD));
    assign jready = !sv_reg || wr;
    assign ld = jvalid && jready;
    assign empty = (cnt_reg == '0);
    assign res = q_mem[rp_reg];
    assign rd = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            sj_reg <= job;
            dx_reg <= dx;
            dy_reg <= dy;
        end
        if (wr)
            q_mem[wp_reg] <= '{px: sj_reg.px, py: sj_reg.py, ex: scale_neg(dx_reg, idx),
                               ey: scale_neg(dy_reg, idy), last: sj_reg.last};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
            sv_reg <= 1'b0;
        end
        else
        begin
            if (ld) sv_reg <= 1'b1;
            else if (wr) sv_reg <= 1'b0;
            if (wr) wp_reg <= wp_reg + 3'd1;
            if (rd) rp_reg <= rp_reg + 3'd1;
            cnt_reg <= cnt_reg + 4'(wr) - 4'(rd);
        end
    end
endmodule

>>> src/field_gradient_2d_stencil.sv
// Path: the first result of a sample passes the job list, the line-buffer read registers,
// the back's difference registers and the result queue; a point that reads three entries
// of one line (edge rows, x lines 0 and cols-1) needs a second read, as a line gives two a cycle.
// A new sample is refused (full) until all jobs of the last one are sent; x < 2 makes no jobs.
// Reset: rst_n async low clears counters and queue; registers take
// their reset values, line buffers stay undefined until written.
module field_gradient_2d_stencil (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [31:0] phi,
    output logic        empty,
    input  logic        pop,
    output logic [9:0]  pos_x,
    output logic [9:0]  pos_y,
    output logic [31:0] ex,
    output logic [31:0] ey,
    output logic        last
);
    import fgs_pkg::*;

    logic [10:0] cols_reg, rows_reg;
    logic [31:0] idx_reg, idy_reg;
    logic        wen, restart;
    reg_idx_t    ri;
    assign pready = 1'b1;
    assign wen = psel && penable && pwrite;
    assign ri = reg_idx_t'(paddr[3:2]);
    assign restart = wen && (ri == REG_COLS || ri == REG_ROWS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= 11'd256;
            rows_reg <= 11'd256;
            idx_reg <= 32'd32768;
            idy_reg <= 32'd32768;
        end
        else if (wen)
        begin
            case (ri)
                REG_COLS: cols_reg <= pwdata[10:0];
                REG_ROWS: rows_reg <= pwdata[10:0];
                REG_IDX:  idx_reg <= pwdata;
                REG_IDY:  idy_reg <= pwdata;
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (ri)
            REG_COLS: prdata = {21'd0, cols_reg};
            REG_ROWS: prdata = {21'd0, rows_reg};
            REG_IDX:  prdata = idx_reg;
            REG_IDY:  prdata = idy_reg;
            default:  prdata = '0;
        endcase
    end

    logic jvalid, jready;
    job_t job;
    logic [31:0] s0, s1, s2, t0, t1, t2;
    res_t res;

    fgs_front u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .phi(phi),
        .cols_cfg(cols_reg), .rows_cfg(rows_reg), .restart(restart),
        .jvalid(jvalid), .job(job), .jready(jready),
        .s0(s0), .s1(s1), .s2(s2), .t0(t0), .t1(t1), .t2(t2)
    );

    fgs_back u_back (
        .clk(clk), .rst_n(rst_n), .jvalid(jvalid), .job(job), .jready(jready),
        .s0(s0), .s1(s1), .s2(s2), .t0(t0), .t1(t1), .t2(t2),
        .rows_cfg(rows_reg), .idx(idx_reg), .idy(idy_reg),
        .empty(empty), .pop(pop), .res(res)
    );

    assign pos_x = res.px;
    assign pos_y = res.py;
    assign ex = res.ex;
    assign ey = res.ey;
    assign last = res.last;
endmodule

>>> src/fgs_checker.sv
// Port-level checker for the gradient stencil, bound to the top level
`include "assert_macros.svh"
module fgs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pop,
    input logic        empty,
    input logic        pready,
    input logic [9:0]  pos_x,
    input logic [9:0]  pos_y
);
    `ASSERT_CLK(a_pready, clk, rst_n, pready, "pready low")
    `ASSERT_CLK(a_hold, clk, rst_n, (!empty && !pop) |=> $stable(pos_x) && $stable(pos_y), "result moved while held")
    `ASSERT_CLK(a_range, clk, rst_n, !empty |-> pos_y < 10'd1023 || pos_x <= 10'd1023, "position out of range")
endmodule

bind field_gradient_2d_stencil fgs_checker u_chk (
    .clk(clk), .rst_n(rst_n), .pop(pop), .empty(empty), .pready(pready),
    .pos_x(pos_x), .pos_y(pos_y)
);
